>>> design/micu_pkg.sv
// shared types, command codes and csr constants of the machine interrupt csr unit
// no dependencies; imported by every module of the block
`default_nettype none

package micu_pkg;

    // default size of the csr store
    localparam int CSR_COUNT_DEF = 4096;

    // field widths
    localparam int CMD_W  = 3;
    localparam int ADDR_W = 12;
    localparam int XLEN   = 32;
    localparam int IRQ_W  = 3;
    localparam int CNT_W  = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_STEP  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RAISE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MRET  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WAIT  = 3'd5;

    // csr addresses
    localparam logic [ADDR_W-1:0] ADDR_MSTATUS = 12'h300;
    localparam logic [ADDR_W-1:0] ADDR_MIE     = 12'h304;
    localparam logic [ADDR_W-1:0] ADDR_MTVEC   = 12'h305;
    localparam logic [ADDR_W-1:0] ADDR_MEPC    = 12'h341;
    localparam logic [ADDR_W-1:0] ADDR_MCAUSE  = 12'h342;
    localparam logic [ADDR_W-1:0] ADDR_CYCLE   = 12'hc00;
    localparam logic [ADDR_W-1:0] ADDR_CYCLEH  = 12'hc80;

    // mstatus and mie bit positions
    localparam int MSTATUS_MIE  = 3;
    localparam int MSTATUS_MPIE = 4;
    localparam int MIE_MSIE     = 3;
    localparam int MIE_MTIE     = 7;
    localparam int MIE_MEIE     = 11;

    // pending interrupt bit positions
    localparam int IRQ_SOFT  = 0;
    localparam int IRQ_TIMER = 1;
    localparam int IRQ_EXT   = 2;

    // mcause values for interrupt entry
    localparam logic [XLEN-1:0] CAUSE_SOFT  = 32'h8000_0003;
    localparam logic [XLEN-1:0] CAUSE_TIMER = 32'h8000_0007;
    localparam logic [XLEN-1:0] CAUSE_EXT   = 32'h8000_000b;

    // one accepted input word
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [XLEN-1:0]   pc;
        logic [IRQ_W-1:0]  irq_mask;
        logic [ADDR_W-1:0] csr_addr;
        logic [XLEN-1:0]   write_value;
    } t_cmd_word;

    // one result word
    typedef struct packed {
        logic            executes;
        logic            redirect;
        logic [XLEN-1:0] target_pc;
        logic [XLEN-1:0] read_value;
    } t_result;

    // access request to the csr memory
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [XLEN-1:0]   wdata;
    } t_mem_req;

endpackage

`default_nettype wire

>>> design/micu_csr_mem.sv
// general csr store: single-port memory with registered read and a zeroing sweep after reset
// depends on micu_pkg
`default_nettype none

module micu_csr_mem #(
    parameter int CSR_COUNT = micu_pkg::CSR_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire micu_pkg::t_mem_req i_req,
    output logic [micu_pkg::XLEN-1:0] o_rdata,
    output logic                    o_clr_busy
);
    import micu_pkg::*;

    localparam int AW = $clog2(CSR_COUNT);
    localparam logic [AW-1:0] LAST_IDX = AW'(CSR_COUNT - 1);

    logic [XLEN-1:0] r_mem [CSR_COUNT];
    logic [XLEN-1:0] r_rdata;
    logic [AW-1:0]   r_clr_idx;
    logic            r_clr_busy;
    logic [AW-1:0]   w_idx;

    assign w_idx = i_req.addr[AW-1:0];

    // clearing sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // storage array
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[w_idx] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[w_idx];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clr_busy = r_clr_busy;

endmodule

`default_nettype wire

>>> design/micu_trap_core.sv
// trap and csr state: machine csrs, pending bits, wait flag, retired counter and result logic
// depends on micu_pkg
`default_nettype none

module micu_trap_core #(
    parameter int CSR_COUNT = micu_pkg::CSR_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_fire,
    input  wire micu_pkg::t_cmd_word   i_word,
    input  wire logic [micu_pkg::XLEN-1:0] i_mem_rdata,
    output micu_pkg::t_result          o_result
);
    import micu_pkg::*;

    logic [XLEN-1:0]  r_mstatus, n_mstatus;
    logic [XLEN-1:0]  r_mie, n_mie;
    logic [XLEN-1:0]  r_mtvec, n_mtvec;
    logic [XLEN-1:0]  r_mepc, n_mepc;
    logic [XLEN-1:0]  r_mcause, n_mcause;
    logic [IRQ_W-1:0] r_pending, n_pending;
    logic             r_waiting, n_waiting;
    logic [CNT_W-1:0] r_retired, n_retired;

    logic [IRQ_W-1:0] w_allowed;
    logic [IRQ_W-1:0] w_active;
    logic             w_in_range;
    t_result          w_res;

    assign w_in_range = ({1'b0, i_word.csr_addr} < (ADDR_W + 1)'(CSR_COUNT));

    // enabled and pending interrupts
    always_comb begin
        w_allowed[IRQ_SOFT]  = r_mie[MIE_MSIE];
        w_allowed[IRQ_TIMER] = r_mie[MIE_MTIE];
        w_allowed[IRQ_EXT]   = r_mie[MIE_MEIE];
        w_active = r_pending & w_allowed;
    end

    // next state and result for the word in flight
    always_comb begin
        n_mstatus = r_mstatus;
        n_mie     = r_mie;
        n_mtvec   = r_mtvec;
        n_mepc    = r_mepc;
        n_mcause  = r_mcause;
        n_pending = r_pending;
        n_waiting = r_waiting;
        n_retired = r_retired;
        w_res     = '0;

        unique case (i_word.command)
            CMD_STEP: begin
                if (!(r_waiting && r_pending == '0)) begin
                    // interrupt entry before the instruction runs
                    if (r_mstatus[MSTATUS_MIE] && w_active != '0) begin
                        n_mepc = i_word.pc;
                        priority if (w_active[IRQ_TIMER]) begin
                            n_mcause = CAUSE_TIMER;
                            n_pending[IRQ_TIMER] = 1'b0;
                        end else if (w_active[IRQ_EXT]) begin
                            n_mcause = CAUSE_EXT;
                            n_pending[IRQ_EXT] = 1'b0;
                        end else begin
                            n_mcause = CAUSE_SOFT;
                            n_pending[IRQ_SOFT] = 1'b0;
                        end
                        n_mstatus[MSTATUS_MPIE] = 1'b1;
                        n_mstatus[MSTATUS_MIE]  = 1'b0;
                        n_waiting       = 1'b0;
                        w_res.redirect  = 1'b1;
                        w_res.target_pc = r_mtvec;
                    end
                    w_res.executes = 1'b1;
                    n_retired      = r_retired + 1'b1;
                end
            end
            CMD_RAISE: begin
                n_pending = r_pending | i_word.irq_mask;
            end
            CMD_MRET: begin
                n_mstatus[MSTATUS_MIE]  = r_mstatus[MSTATUS_MPIE];
                n_mstatus[MSTATUS_MPIE] = 1'b0;
                w_res.redirect  = 1'b1;
                w_res.target_pc = r_mepc;
            end
            CMD_READ: begin
                priority if (i_word.csr_addr == ADDR_CYCLE) begin
                    w_res.read_value = r_retired[XLEN-1:0];
                end else if (i_word.csr_addr == ADDR_CYCLEH) begin
                    w_res.read_value = r_retired[CNT_W-1:XLEN];
                end else if (!w_in_range) begin
                    w_res.read_value = '0;
                end else if (i_word.csr_addr == ADDR_MSTATUS) begin
                    w_res.read_value = r_mstatus;
                end else if (i_word.csr_addr == ADDR_MIE) begin
                    w_res.read_value = r_mie;
                end else if (i_word.csr_addr == ADDR_MTVEC) begin
                    w_res.read_value = r_mtvec;
                end else if (i_word.csr_addr == ADDR_MEPC) begin
                    w_res.read_value = r_mepc;
                end else if (i_word.csr_addr == ADDR_MCAUSE) begin
                    w_res.read_value = r_mcause;
                end else begin
                    w_res.read_value = i_mem_rdata;
                end
            end
            CMD_WRITE: begin
                // the memory copy is written at accept; machine csrs live here
                unique case (i_word.csr_addr)
                    ADDR_MSTATUS: n_mstatus = i_word.write_value;
                    ADDR_MIE:     n_mie     = i_word.write_value;
                    ADDR_MTVEC:   n_mtvec   = i_word.write_value;
                    ADDR_MEPC:    n_mepc    = i_word.write_value;
                    ADDR_MCAUSE:  n_mcause  = i_word.write_value;
                    default: ;
                endcase
            end
            CMD_WAIT: begin
                n_waiting = 1'b1;
            end
            default: ;
        endcase
    end

    // state update when the word leaves this stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstatus <= '0;
            r_mie     <= '0;
            r_mtvec   <= '0;
            r_mepc    <= '0;
            r_mcause  <= '0;
            r_pending <= '0;
            r_waiting <= 1'b0;
            r_retired <= '0;
        end else if (i_fire) begin
            r_mstatus <= n_mstatus;
            r_mie     <= n_mie;
            r_mtvec   <= n_mtvec;
            r_mepc    <= n_mepc;
            r_mcause  <= n_mcause;
            r_pending <= n_pending;
            r_waiting <= n_waiting;
            r_retired <= n_retired;
        end
    end

    assign o_result = w_res;

endmodule

`default_nettype wire

>>> design/machine_interrupt_csr_unit.sv
// top level of the machine interrupt csr unit: input register, result register, handshakes
// depends on micu_pkg, micu_csr_mem and micu_trap_core
`default_nettype none

// Machine-mode trap and csr unit. It takes one command word per clock while o_in_ready is
// high and gives one result word per command, in order. The word is accepted into the input
// register as the general csr memory is read into a registered read port, then the trap and
// csr logic works on the word into the result register. The one memory port (read or write
// at accept) and the single trap stage set the rate of one word per cycle while neither
// channel stalls. After reset the csr memory is zeroed by a sweep, during which o_in_ready
// stays low. Machine csrs (mstatus, mie, mtvec, mepc, mcause), the pending bits, the wait
// flag and the 64-bit retired counter are flip-flops read in the same cycle.
module machine_interrupt_csr_unit #(
    parameter int CSR_COUNT = micu_pkg::CSR_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [micu_pkg::CMD_W-1:0]    i_command,
    input  wire logic [micu_pkg::XLEN-1:0]     i_pc,
    input  wire logic [micu_pkg::IRQ_W-1:0]    i_irq_mask,
    input  wire logic [micu_pkg::ADDR_W-1:0]   i_csr_addr,
    input  wire logic [micu_pkg::XLEN-1:0]     i_write_value,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_executes,
    output logic                               o_redirect,
    output logic [micu_pkg::XLEN-1:0]          o_target_pc,
    output logic [micu_pkg::XLEN-1:0]          o_read_value
);
    import micu_pkg::*;

    logic      r_in_valid;
    t_cmd_word r_in;
    logic      r_out_valid;
    t_result   r_out;

    logic      w_clr_busy;
    logic      w_out_adv;
    logic      w_s1_fire;
    logic      w_in_fire;
    logic      w_in_range;
    t_mem_req  w_mem_req;
    t_result   w_result;
    logic [XLEN-1:0] w_mem_rdata;

    // handshake flow
    assign w_out_adv  = !r_out_valid || i_out_ready;
    assign w_s1_fire  = r_in_valid && w_out_adv;
    assign o_in_ready = !w_clr_busy && (!r_in_valid || w_out_adv);
    assign w_in_fire  = i_in_valid && o_in_ready;

    // memory access at accept
    assign w_in_range = ({1'b0, i_csr_addr} < (ADDR_W + 1)'(CSR_COUNT));
    always_comb begin
        w_mem_req.wr_en = w_in_fire && (i_command == CMD_WRITE) && w_in_range;
        w_mem_req.rd_en = w_in_fire && (i_command == CMD_READ) && w_in_range;
        w_mem_req.addr  = i_csr_addr;
        w_mem_req.wdata = i_write_value;
    end

    micu_csr_mem #(
        .CSR_COUNT (CSR_COUNT)
    ) u_csr_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_mem_req),
        .o_rdata    (w_mem_rdata),
        .o_clr_busy (w_clr_busy)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in.command     <= i_command;
            r_in.pc          <= i_pc;
            r_in.irq_mask    <= i_irq_mask;
            r_in.csr_addr    <= i_csr_addr;
            r_in.write_value <= i_write_value;
        end
    end

    micu_trap_core #(
        .CSR_COUNT (CSR_COUNT)
    ) u_trap_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_s1_fire),
        .i_word      (r_in),
        .i_mem_rdata (w_mem_rdata),
        .o_result    (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_executes   = r_out.executes;
    assign o_redirect   = r_out.redirect;
    assign o_target_pc  = r_out.target_pc;
    assign o_read_value = r_out.read_value;

`ifndef ASSERT_OFF
    // no word is taken while the csr memory is being zeroed
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !o_in_ready)
        else $error("word accepted during csr clearing sweep");

    // a read result never carries a step or redirect
    a_read_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_value != '0) |-> (!o_executes && !o_redirect))
        else $error("read value mixed with step or redirect result");

    // target pc is zero unless fetch is redirected
    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_redirect) |-> (o_target_pc == '0))
        else $error("target pc set without redirect");
`endif

endmodule

`default_nettype wire

>>> sim/tb_machine_interrupt_csr_unit.sv
// testbench for machine_interrupt_csr_unit: directed and random command words with a scoreboard
// depends on micu_pkg and machine_interrupt_csr_unit; self-contained, no external files
`timescale 1ns / 100ps

module tb_machine_interrupt_csr_unit;
    import micu_pkg::*;

    localparam int          CSR_COUNT    = CSR_COUNT_DEF;
    localparam int          STALL_LIMIT  = 20000;
    localparam int          WORD_TARGET  = 1175;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          HOLD_AT      = 600;
    localparam logic [2:0]  CMD_RSVD6    = 3'd6;
    localparam logic [2:0]  CMD_RSVD7    = 3'd7;
    localparam logic [11:0] ADDR_TIME    = 12'hc01;
    localparam logic [11:0] ADDR_TIMEH   = 12'hc81;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // driven command word and handshakes
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_cmd_word drv_word  = '0;

    logic            o_in_ready;
    logic            o_out_valid;
    logic            o_executes;
    logic            o_redirect;
    logic [XLEN-1:0] o_target_pc;
    logic [XLEN-1:0] o_read_value;

    // stimulus and scoreboard
    t_cmd_word cmd_q[$];
    t_result   result_q[$];
    int        mismatches   = 0;
    int        tx_count     = 0;
    int        rx_count     = 0;
    int        hold_left    = 0;
    logic      held_once    = 1'b0;
    int        stall_cycles = 0;

    // shadow state of the trap unit
    logic [XLEN-1:0]  csr_model [CSR_COUNT];
    logic [IRQ_W-1:0] irq_pend  = '0;
    logic             sleeping  = 1'b0;
    logic [CNT_W-1:0] retired   = '0;

    machine_interrupt_csr_unit #(.CSR_COUNT(CSR_COUNT)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (drv_word.command),
        .i_pc          (drv_word.pc),
        .i_irq_mask    (drv_word.irq_mask),
        .i_csr_addr    (drv_word.csr_addr),
        .i_write_value (drv_word.write_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_executes    (o_executes),
        .o_redirect    (o_redirect),
        .o_target_pc   (o_target_pc),
        .o_read_value  (o_read_value)
    );

    always #1 i_clk = ~i_clk;

    // outcome of one command word, updating the shadow state
    function automatic t_result trap_csr_outcome(input t_cmd_word w);
        t_result          r;
        logic [XLEN-1:0]  st;
        logic [XLEN-1:0]  en;
        logic [XLEN-1:0]  cause;
        logic [IRQ_W-1:0] act;
        logic [IRQ_W-1:0] take;
        r = '0;
        case (w.command)
            CMD_STEP: begin
                if (!(sleeping && irq_pend == '0)) begin
                    st = csr_model[ADDR_MSTATUS];
                    en = csr_model[ADDR_MIE];
                    act = irq_pend & {en[MIE_MEIE], en[MIE_MTIE], en[MIE_MSIE]};
                    if (st[MSTATUS_MIE] && act != '0) begin
                        // priority timer, external, software
                        take = '0;
                        if (act[IRQ_TIMER]) begin
                            take[IRQ_TIMER] = 1'b1;
                            cause = CAUSE_TIMER;
                        end else if (act[IRQ_EXT]) begin
                            take[IRQ_EXT] = 1'b1;
                            cause = CAUSE_EXT;
                        end else begin
                            take[IRQ_SOFT] = 1'b1;
                            cause = CAUSE_SOFT;
                        end
                        csr_model[ADDR_MEPC]   = w.pc;
                        csr_model[ADDR_MCAUSE] = cause;
                        st[MSTATUS_MPIE] = st[MSTATUS_MIE];
                        st[MSTATUS_MIE]  = 1'b0;
                        csr_model[ADDR_MSTATUS] = st;
                        r.redirect  = 1'b1;
                        r.target_pc = csr_model[ADDR_MTVEC];
                        irq_pend    = irq_pend & ~take;
                        sleeping    = 1'b0;
                    end
                    r.executes = 1'b1;
                    retired    = retired + 1'b1;
                end
            end
            CMD_RAISE: irq_pend = irq_pend | w.irq_mask;
            CMD_MRET: begin
                st = csr_model[ADDR_MSTATUS];
                st[MSTATUS_MIE]  = st[MSTATUS_MPIE];
                st[MSTATUS_MPIE] = 1'b0;
                csr_model[ADDR_MSTATUS] = st;
                r.redirect  = 1'b1;
                r.target_pc = csr_model[ADDR_MEPC];
            end
            CMD_READ: begin
                if (w.csr_addr == ADDR_CYCLE)
                    r.read_value = retired[31:0];
                else if (w.csr_addr == ADDR_CYCLEH)
                    r.read_value = retired[63:32];
                else if (int'(w.csr_addr) < CSR_COUNT)
                    r.read_value = csr_model[w.csr_addr];
            end
            CMD_WRITE: begin
                if (int'(w.csr_addr) < CSR_COUNT)
                    csr_model[w.csr_addr] = w.write_value;
            end
            CMD_WAIT: sleeping = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    task automatic enqueue_cmd(input logic [2:0] c, input logic [31:0] p, input logic [2:0] m,
                               input logic [11:0] a, input logic [31:0] v);
        t_cmd_word w;
        w.command     = c;
        w.pc          = p;
        w.irq_mask    = m;
        w.csr_addr    = a;
        w.write_value = v;
        cmd_q.push_back(w);
    endtask

    // mostly the interesting csr addresses, sometimes any address
    function automatic logic [11:0] pick_addr();
        logic [11:0] hot [11];
        hot = '{ADDR_MSTATUS, ADDR_MIE, ADDR_MTVEC, ADDR_MEPC, ADDR_MCAUSE, ADDR_CYCLE,
                ADDR_CYCLEH, ADDR_TIME, ADDR_TIMEH, 12'h000, 12'hfff};
        if ($urandom_range(0, 99) < 60)
            return hot[4'($urandom_range(0, 10))];
        return 12'($urandom_range(0, 4095));
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // driver: offers queued words, idles at random outside the calm window
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                result_q.push_back(trap_csr_outcome(drv_word));
                tx_count <= tx_count + 1;
            end
            if (!in_valid || o_in_ready) begin
                if (cmd_q.size() != 0 &&
                    ((tx_count >= 300 && tx_count < 500) || $urandom_range(0, 99) >= 22)) begin
                    drv_word <= cmd_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word, random backpressure plus one long hold-off
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        logic    hold_now;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                got = '{o_executes, o_redirect, o_target_pc, o_read_value};
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result word, actual %h", $time, got);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    check_field("executes", 32'(want.executes), 32'(got.executes));
                    check_field("redirect", 32'(want.redirect), 32'(got.redirect));
                    check_field("target_pc", want.target_pc, got.target_pc);
                    check_field("read_value", want.read_value, got.read_value);
                end
                rx_count <= rx_count + 1;
            end
            hold_now = (hold_left > 0) || (!held_once && rx_count >= HOLD_AT);
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (hold_now) begin
                hold_left <= HOLD_CYCLES;
                held_once <= 1'b1;
            end
            if (hold_now)
                out_ready <= 1'b0;
            else
                out_ready <= (rx_count >= 300 && rx_count < 500) || ($urandom_range(0, 99) >= 22);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [31:0] v;
        int          n;
        foreach (csr_model[i])
            csr_model[i] = '0;

        // directed: extremes, counter and time csrs, wait stall, priorities, mret, reserved
        enqueue_cmd(CMD_READ, '1, '1, '1, '1);
        enqueue_cmd(CMD_STEP, '0, '0, '0, '0);
        enqueue_cmd(CMD_STEP, '1, '1, '1, '1);
        enqueue_cmd(CMD_READ, $urandom, 3'($urandom), ADDR_CYCLE, $urandom);
        enqueue_cmd(CMD_READ, $urandom, 3'($urandom), ADDR_CYCLEH, $urandom);
        enqueue_cmd(CMD_WRITE, $urandom, 3'($urandom), ADDR_CYCLE, '1);
        enqueue_cmd(CMD_READ, $urandom, 3'($urandom), ADDR_CYCLE, $urandom);
        enqueue_cmd(CMD_WRITE, $urandom, 3'($urandom), ADDR_TIME, 32'h1234_5678);
        enqueue_cmd(CMD_READ, $urandom, 3'($urandom), ADDR_TIME, $urandom);
        enqueue_cmd(CMD_WAIT, $urandom, 3'($urandom), 12'($urandom), $urandom);
        enqueue_cmd(CMD_STEP, $urandom, 3'($urandom), 12'($urandom), $urandom);
        // pending but not enabled: no stall
        enqueue_cmd(CMD_RAISE, $urandom, 3'b001, 12'($urandom), $urandom);
        enqueue_cmd(CMD_STEP, $urandom, 3'($urandom), 12'($urandom), $urandom);
        enqueue_cmd(CMD_WRITE, $urandom, 3'($urandom), ADDR_MTVEC, 32'h8000_0100);
        enqueue_cmd(CMD_WRITE, $urandom, 3'($urandom), ADDR_MIE, 32'h0000_0888);
        enqueue_cmd(CMD_RAISE, $urandom, 3'b111, 12'($urandom), $urandom);
        enqueue_cmd(CMD_WRITE, $urandom, 3'($urandom), ADDR_MSTATUS, 32'h0000_0008);
        // timer, then external, then software
        enqueue_cmd(CMD_STEP, 32'h0000_0400, 3'($urandom), 12'($urandom), $urandom);
        enqueue_cmd(CMD_READ, $urandom, 3'($urandom), ADDR_MCAUSE, $urandom);
        enqueue_cmd(CMD_MRET, $urandom, 3'($urandom), 12'($urandom), $urandom);
        enqueue_cmd(CMD_STEP, 32'h0000_0800, 3'($urandom), 12'($urandom), $urandom);
        enqueue_cmd(CMD_MRET, $urandom, 3'($urandom), 12'($urandom), $urandom);
        enqueue_cmd(CMD_STEP, 32'h0000_0c00, 3'($urandom), 12'($urandom), $urandom);
        enqueue_cmd(CMD_RSVD6, $urandom, 3'($urandom), 12'($urandom), $urandom);
        enqueue_cmd(CMD_RSVD7, $urandom, 3'($urandom), 12'($urandom), $urandom);

        // random: trap sequences with random content, mixed with single noise words
        while (cmd_q.size() < WORD_TARGET) begin
            if ($urandom_range(0, 99) < 45) begin
                if ($urandom_range(0, 1))
                    enqueue_cmd(CMD_WRITE, $urandom, 3'($urandom), ADDR_MTVEC, $urandom);
                if ($urandom_range(0, 1))
                    enqueue_cmd(CMD_WRITE, $urandom, 3'($urandom), ADDR_MIE, $urandom);
                v = $urandom;
                if ($urandom_range(0, 9) < 8)
                    v[MSTATUS_MIE] = 1'b1;
                enqueue_cmd(CMD_WRITE, $urandom, 3'($urandom), ADDR_MSTATUS, v);
                enqueue_cmd(CMD_RAISE, $urandom, 3'($urandom_range(1, 7)), 12'($urandom),
                            $urandom);
                if ($urandom_range(0, 3) == 0)
                    enqueue_cmd(CMD_WAIT, $urandom, 3'($urandom), 12'($urandom), $urandom);
                n = $urandom_range(1, 3);
                repeat (n)
                    enqueue_cmd(CMD_STEP, $urandom, 3'($urandom), 12'($urandom), $urandom);
                enqueue_cmd(CMD_READ, $urandom, 3'($urandom), pick_addr(), $urandom);
                if ($urandom_range(0, 9) < 7)
                    enqueue_cmd(CMD_MRET, $urandom, 3'($urandom), 12'($urandom), $urandom);
                enqueue_cmd(CMD_STEP, $urandom, 3'($urandom), 12'($urandom), $urandom);
            end else begin
                n = $urandom_range(0, 99);
                enqueue_cmd(n < 28 ? CMD_STEP : n < 40 ? CMD_RAISE : n < 48 ? CMD_MRET :
                            n < 68 ? CMD_READ : n < 88 ? CMD_WRITE : n < 96 ? CMD_WAIT :
                            (n[0] ? CMD_RSVD7 : CMD_RSVD6),
                            $urandom, 3'($urandom), pick_addr(), $urandom);
            end
        end

        // synchronous reset, then let the driver drain the queue
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_q.size() != 0 || in_valid)
            @(negedge i_clk);
        while (result_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
